/* src/lpht_pkg.sv */
// Shared types and constants for the linear-probe hash table unit.
package lpht_pkg;

  // Default number of slots in the table.
  localparam int TABLE_SIZE_DEF = 16;

  // Fixed field widths.
  localparam int KEY_W  = 16;
  localparam int SLOT_W = 4;

  // Request action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

/* src/lpht_if.sv */
// Request and result channel interfaces for the linear-probe hash table unit.
interface lpht_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [lpht_pkg::KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface lpht_out_if;
  logic                       valid;
  logic                       ready;
  lpht_pkg::status_t          status;
  logic [lpht_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

/* src/linear_probe_hash_table_unit.sv */
// Linear-probe hash table: top level with slot key memory and probe sequencer.
// Flow: after acceptance the key is hashed to its home slot, then the probe passes occupied
//   slots, one step each for an insert or a key read and compare for a search, and the result
//   loads into the output register; an insert into a full table goes straight to the result.
// Requests: one at a time, a new one accepted only after the previous result loads; the hash
//   and the probe loop set the pace, and a held output stalls the result load.
// Reset: synchronous, clears all slot valid bits and the occupancy count at once.
module linear_probe_hash_table_unit #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_PROBE = 5'b00100,
    S_CMP   = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       act_r, act_nxt;
  logic [lpht_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [IW-1:0]              slot_r, slot_nxt;
  logic [IW-1:0]              steps_r, steps_nxt;
  lpht_pkg::status_t          res_status_r, res_status_nxt;
  logic [IW-1:0]              res_slot_r, res_slot_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lpht_pkg::status_t          out_status_r, out_status_nxt;
  logic [lpht_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [TABLE_SIZE-1:0]      valid_r, valid_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [lpht_pkg::KEY_W-1:0] rd_key_r;

  logic                       mem_we;
  logic                       mem_re;
  logic                       mod_start;
  logic                       mod_done;
  logic [IW-1:0]              mod_rem;
  logic                       full;
  logic [IW-1:0]              slot_next;

  // Slot key store: one write or one read per cycle, registered read data
  logic [lpht_pkg::KEY_W-1:0] key_mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[slot_r] <= key_r;
    end
    if (mem_re) begin
      rd_key_r <= key_mem[slot_r];
    end
  end

  // Home slot hash
  lpht_mod #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_ch.key),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign full      = (count_r == CW'(TABLE_SIZE));
  assign slot_next = (slot_r == IW'(TABLE_SIZE - 1)) ? '0 : slot_r + 1'b1;

  // Probe sequencer
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    slot_nxt       = slot_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mod_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt = in_ch.action;
          key_nxt = in_ch.key;
          if (in_ch.action == lpht_pkg::ACT_INSERT && full) begin
            res_status_nxt = lpht_pkg::ST_FULL;
            res_slot_nxt   = '0;
            state_nxt      = S_RESP;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (mod_done) begin
          slot_nxt  = mod_rem;
          steps_nxt = '0;
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        if (!valid_r[slot_r]) begin
          // Empty slot ends both kinds of probe
          if (act_r == lpht_pkg::ACT_INSERT) begin
            mem_we            = 1'b1;
            valid_nxt[slot_r] = 1'b1;
            count_nxt         = count_r + 1'b1;
            res_status_nxt    = lpht_pkg::ST_INSERTED;
            res_slot_nxt      = slot_r;
          end else begin
            res_status_nxt = lpht_pkg::ST_MISSING;
            res_slot_nxt   = '0;
          end
          state_nxt = S_RESP;
        end else if (act_r == lpht_pkg::ACT_INSERT) begin
          // Count below capacity guarantees an empty slot ahead
          slot_nxt = slot_next;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        if (rd_key_r == key_r) begin
          res_status_nxt = lpht_pkg::ST_FOUND;
          res_slot_nxt   = slot_r;
          state_nxt      = S_RESP;
        end else if (steps_r == IW'(TABLE_SIZE - 1)) begin
          // Wrapped back to the home slot
          res_status_nxt = lpht_pkg::ST_MISSING;
          res_slot_nxt   = '0;
          state_nxt      = S_RESP;
        end else begin
          slot_nxt  = slot_next;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_PROBE;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = lpht_pkg::SLOT_W'(res_slot_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    slot_r       <= slot_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

endmodule

/* src/lpht_mod.sv */
// Remainder unit: key modulo TABLE_SIZE by reciprocal multiplication, quotient then remainder registered.
module lpht_mod #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpht_pkg::KEY_W-1:0]    dividend,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);

  localparam int     IW     = $clog2(TABLE_SIZE);
  localparam int     KW     = lpht_pkg::KEY_W;
  // Reciprocal ceil(2^SHIFT / TABLE_SIZE) is exact for every KW-bit key
  localparam int     SHIFT  = KW + IW;
  localparam longint MUL    = ((longint'(1) << SHIFT) + longint'(TABLE_SIZE) - 1)
                              / longint'(TABLE_SIZE);
  localparam int     MUL_W  = KW + 2;
  localparam int     PROD_W = KW + MUL_W;

  logic              stage_r;
  logic              done_r;
  logic [KW-1:0]     key_r;
  logic [KW-1:0]     quot_r;
  logic [IW-1:0]     rem_r;
  logic [PROD_W-1:0] prod;
  logic [KW-1:0]     quot_nxt;
  logic [KW-1:0]     diff;
  logic [IW-1:0]     rem_nxt;

  // Quotient from the reciprocal product
  assign prod     = PROD_W'(dividend) * PROD_W'(MUL);
  assign quot_nxt = KW'(prod >> SHIFT);

  // Remainder from the quotient
  assign diff    = key_r - quot_r * KW'(TABLE_SIZE);
  assign rem_nxt = IW'(diff);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      key_r  <= dividend;
      quot_r <= quot_nxt;
    end
    if (stage_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* verif/tb_linear_probe_hash_table_unit.sv */
// Testbench for the linear-probe hash table unit: directed and random insert/search traffic.
module tb_linear_probe_hash_table_unit;
  import lpht_pkg::*;

  localparam int TBL_SIZE     = TABLE_SIZE_DEF;
  localparam int CLK_HALF     = 5;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1670;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  lpht_in_if  in_ch();
  lpht_out_if out_ch();

  linear_probe_hash_table_unit #(
    .TABLE_SIZE(TBL_SIZE)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the table contents
  logic             shadow_used [TBL_SIZE];
  logic [KEY_W-1:0] shadow_key  [TBL_SIZE];
  int unsigned      shadow_count;
  logic [KEY_W-1:0] stored_keys[$];

  // Answers owed by the block, oldest first
  answer_t answers_due[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_gen = 0;
  int mismatch_count = 0;

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Apply one request to the shadow table and return the answer it should get
  function automatic answer_t probe_shadow_table(input logic act, input logic [KEY_W-1:0] key);
    int unsigned s;
    int          i;
    answer_t     ans;
    s = key % TBL_SIZE;
    ans.status = ST_MISSING;
    ans.slot   = '0;
    if (act == ACT_INSERT) begin
      ans.status = ST_FULL;
      if (shadow_count < TBL_SIZE) begin
        for (i = 0; i < TBL_SIZE; i++) begin
          if (!shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_key[s]  = key;
            shadow_count++;
            stored_keys.push_back(key);
            ans.status = ST_INSERTED;
            ans.slot   = s[SLOT_W-1:0];
            break;
          end
          s = (s + 1) % TBL_SIZE;
        end
      end
    end else begin
      // stop at an empty slot, the key, or after a full lap
      for (i = 0; i < TBL_SIZE; i++) begin
        if (!shadow_used[s]) break;
        if (shadow_key[s] == key) begin
          ans.status = ST_FOUND;
          ans.slot   = s[SLOT_W-1:0];
          break;
        end
        s = (s + 1) % TBL_SIZE;
      end
    end
    return ans;
  endfunction

  // Send one request; called at a falling edge, returns at a falling edge with valid still up
  task automatic send_request(input logic act, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.key    <= key;
    do @(posedge clk); while (!in_ch.ready);
    answers_due.push_back(probe_shadow_table(act, key));
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed answer has come back
  task automatic wait_for_answers();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (answers_due.size() != 0) @(negedge clk);
  endtask

  // Random request against a loaded table: hits, same-home misses, wild keys, inserts
  task automatic send_random_request();
    int               pick;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] known;
    pick  = $urandom_range(99);
    key   = KEY_W'($urandom_range(16'hFFFF));
    known = stored_keys[$urandom_range(stored_keys.size() - 1)];
    if (pick < 60)
      send_request(ACT_SEARCH, known);
    else if (pick < 80)
      send_request(ACT_SEARCH, {key[KEY_W-1:4], known[3:0]});
    else if (pick < 90)
      send_request(ACT_SEARCH, key);
    else
      send_request(ACT_INSERT, key);
  endtask

  task automatic test_empty_table();
    // search on an empty table stops at the empty home slot
    send_request(ACT_SEARCH, 16'h0000);
    send_request(ACT_SEARCH, 16'hFFFF);
  endtask

  task automatic test_collision_and_duplicate();
    send_request(ACT_INSERT, 16'd0);
    send_request(ACT_INSERT, 16'd16);   // same home, lands one slot on
    send_request(ACT_INSERT, 16'd0);    // duplicate stored again further along
    send_request(ACT_SEARCH, 16'd0);    // first copy wins
    send_request(ACT_SEARCH, 16'd16);
    send_request(ACT_SEARCH, 16'd32);   // walks the cluster, misses at the empty slot
  endtask

  task automatic test_wrap_around();
    send_request(ACT_INSERT, 16'hFFFF); // home is the last slot
    send_request(ACT_INSERT, 16'd15);   // wraps past the end to slot 3
    send_request(ACT_SEARCH, 16'd15);
    send_request(ACT_SEARCH, 16'hFFFF);
  endtask

  task automatic test_fill_to_full();
    logic [KEY_W-1:0] absent;
    while (shadow_count < TBL_SIZE) send_request(ACT_INSERT, KEY_W'($urandom_range(16'hFFFF)));
    send_request(ACT_INSERT, KEY_W'($urandom_range(16'hFFFF)));
    // a key held nowhere makes the search lap the whole full table
    do absent = KEY_W'($urandom_range(16'hFFFF)); while (absent inside {stored_keys});
    send_request(ACT_SEARCH, absent);
  endtask

  task automatic test_output_backpressure();
    int i;
    tx_idle_pct = 0;
    hold_gen <= hold_gen + 1;
    for (i = 0; i < 6; i++) send_random_request();
    wait_for_answers();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    int i;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (i = 0; i < count; i++) send_random_request();
  endtask

  // Result receiver: random ready, or a long hold-off when asked
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_gen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest owed answer
  always @(posedge clk) begin : check_results
    answer_t owed;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (answers_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d slot %0d", out_ch.status, out_ch.slot);
      end else begin
        owed = answers_due.pop_front();
        if (out_ch.status !== owed.status || out_ch.slot !== owed.slot) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     owed.status, owed.slot, out_ch.status, out_ch.slot);
        end
      end
    end
  end

  // Test sequence
  initial begin : run_tests
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.key    = '0;
    tx_idle_pct  = 29;
    rx_idle_pct  = 75;
    shadow_count = 0;
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_collision_and_duplicate();
    test_wrap_around();
    test_fill_to_full();
    wait_for_answers();
    test_output_backpressure();
    test_random_traffic(29, 75, RANDOM_ITEMS / 3);
    test_random_traffic(75, 29, RANDOM_ITEMS / 3);
    test_random_traffic(0, 0, RANDOM_ITEMS / 3);

    wait_for_answers();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(CLK_HALF * 2 * 1_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* linear_probe_hash_table_unit.f */
src/lpht_pkg.sv
src/lpht_if.sv
src/lpht_mod.sv
src/linear_probe_hash_table_unit.sv
verif/tb_linear_probe_hash_table_unit.sv
